@@ rtl/core/fdp_pkg.sv @@
package fdp_pkg;

  localparam int unsigned DataW       = 8;
  localparam int unsigned IdW         = 16;
  localparam int unsigned ResW        = 16;
  localparam int unsigned DiffW       = 14;
  localparam int unsigned PendW       = 6;
  localparam int unsigned LayerW      = 3;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned ResBytes    = 4;
  localparam int unsigned ResIdxW     = 3;
  localparam int unsigned MaxDepsDflt = 8;

  // APB register map
  localparam int unsigned PaddrW           = 3;
  localparam int unsigned PdataW           = 32;
  localparam logic [PaddrW-1:0] AddrDiscard = 3'd0;

  // header byte bit positions
  localparam int unsigned BitBegin    = 7;
  localparam int unsigned BitEnd      = 6;
  localparam int unsigned BitFirst    = 5;
  localparam int unsigned BitLast     = 4;
  localparam int unsigned BitDepFlag  = 3;
  // dependency byte bit positions
  localparam int unsigned BitDepExt   = 1;
  localparam int unsigned BitDepMore  = 0;

  localparam logic KindDiff = 1'b0;
  localparam logic KindDesc = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_REJECTED  = 2'd2
  } status_t;

  typedef enum logic [8:0] {
    PH_FIRST   = 9'b000000001,
    PH_SPATIAL = 9'b000000010,
    PH_FID_LO  = 9'b000000100,
    PH_FID_HI  = 9'b000001000,
    PH_RES     = 9'b000010000,
    PH_DEP     = 9'b000100000,
    PH_DEP_EXT = 9'b001000000,
    PH_TAIL    = 9'b010000000,
    PH_ERR     = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [1:0]         packet_edges;
    logic [1:0]         frame_flags;
    logic [LayerW-1:0]  temporal_layer;
    logic [DataW-1:0]   spatial_mask;
    logic [IdW-1:0]     frame_num;
    logic [ResW-1:0]    width;
    logic [ResW-1:0]    height;
    status_t            status;
  } desc_t;

endpackage

@@ rtl/core/fdp_byte_if.sv @@
interface fdp_byte_if import fdp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data_byte;
  logic             last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ rtl/core/fdp_result_if.sv @@
interface fdp_result_if import fdp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic              run_last;
  logic [1:0]        packet_edges;
  logic [1:0]        frame_flags;
  logic [LayerW-1:0] temporal_layer;
  logic [DataW-1:0]  spatial_mask;
  logic [IdW-1:0]    frame_num;
  logic [ResW-1:0]   width;
  logic [ResW-1:0]   height;
  logic [DiffW-1:0]  dep_diff;
  logic [StatusW-1:0] status;

  modport source (
    output valid, output kind, output run_last, output packet_edges, output frame_flags,
    output temporal_layer, output spatial_mask, output frame_num, output width,
    output height, output dep_diff, output status, input ready
  );
  modport sink (
    input valid, input kind, input run_last, input packet_edges, input frame_flags,
    input temporal_layer, input spatial_mask, input frame_num, input width,
    input height, input dep_diff, input status, output ready
  );
endinterface

@@ rtl/core/frame_descriptor_parser.sv @@
// Frame descriptor parser, one payload byte per transfer.
// Results are registered: a result is offered in the cycle after the byte transfer that causes it.
// Throughput: one byte per cycle while results are taken; a final byte that also completes a
//   difference puts out two results and holds the input until the difference has gone out.
// Reset (rst, synchronous): parser back to awaiting a first byte, all parse
//   state cleared, result buffer empty, discard_mode = 0.
module frame_descriptor_parser import fdp_pkg::*; #(
  parameter int unsigned MAX_DEPENDENCIES = MaxDepsDflt
) (
  input  logic              clk,
  input  logic              rst,
  fdp_byte_if.sink          byte_in,
  fdp_result_if.source      result_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned DepCntW = $clog2(MAX_DEPENDENCIES + 1);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic discard_mode;
  logic sel_discard;

  // word decode: byte lanes within the register all select it
  assign sel_discard = (paddr[PaddrW-1:2] == AddrDiscard[PaddrW-1:2]);

  assign pready = 1'b1;
  assign prdata = sel_discard ? {{(PdataW-1){1'b0}}, discard_mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      discard_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && sel_discard) begin
      discard_mode <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Parse state
  // ---------------------------------------------------------------------------
  phase_t               phase, phase_next;
  logic [DataW-1:0]     header_byte, header_byte_next;
  logic [ResIdxW-1:0]   byte_index, byte_index_next;
  logic [DataW-1:0]     spatial_reg, spatial_reg_next;
  logic [IdW-1:0]       frame_num_reg, frame_num_reg_next;
  logic [2*ResW-1:0]    resolution_reg, resolution_reg_next;
  logic [PendW-1:0]     pending_diff, pending_diff_next;
  logic                 more_pending, more_pending_next;
  logic [DepCntW-1:0]   dep_count, dep_count_next;
  status_t              error_code, error_code_next;

  // Result buffer: up to one difference and one descriptor per byte.
  logic                 diff_valid;
  logic                 desc_valid;
  logic [DiffW-1:0]     diff_data;
  desc_t                desc_data;

  logic                 in_xfer;
  logic                 out_xfer;
  logic [DataW-1:0]     b;
  logic                 last;

  // step outputs
  logic                 try_diff;
  logic                 more_flag;
  logic [DiffW-1:0]     diff_cand;
  logic                 diff_emit;
  status_t              fail_code;
  logic [ResIdxW-1:0]   idx_inc;
  desc_t                desc_next;

  assign b        = byte_in.data_byte;
  assign last     = byte_in.last_byte;
  assign in_xfer  = byte_in.valid && byte_in.ready;
  assign out_xfer = result_out.valid && result_out.ready;

  // Take a byte when the buffer will be empty after this cycle.
  assign byte_in.ready = (!diff_valid && !desc_valid) ||
                         (result_out.ready && !(diff_valid && desc_valid));

  assign idx_inc = byte_index + ResIdxW'(1);

  always_comb begin
    phase_next          = phase;
    header_byte_next    = header_byte;
    byte_index_next     = byte_index;
    spatial_reg_next    = spatial_reg;
    frame_num_reg_next  = frame_num_reg;
    resolution_reg_next = resolution_reg;
    pending_diff_next   = pending_diff;
    more_pending_next   = more_pending;
    dep_count_next      = dep_count;
    error_code_next     = error_code;
    try_diff            = 1'b0;
    more_flag           = 1'b0;
    diff_cand           = '0;
    diff_emit           = 1'b0;
    fail_code           = ST_OK;

    unique case (phase)
      PH_FIRST: begin
        // every payload starts from a clean slate
        byte_index_next     = '0;
        spatial_reg_next    = '0;
        frame_num_reg_next  = '0;
        resolution_reg_next = '0;
        pending_diff_next   = '0;
        more_pending_next   = 1'b0;
        dep_count_next      = '0;
        error_code_next     = ST_OK;
        header_byte_next    = b;
        if (b[BitBegin]) begin
          phase_next = PH_SPATIAL;
          if (last) fail_code = ST_MALFORMED;
        end else if (!last) begin
          fail_code = ST_MALFORMED;  // non-begin packet must be one byte
        end
      end
      PH_SPATIAL: begin
        spatial_reg_next = b;
        phase_next       = PH_FID_LO;
        if (last) fail_code = ST_MALFORMED;
      end
      PH_FID_LO: begin
        frame_num_reg_next = {{(IdW-DataW){1'b0}}, b};
        phase_next         = PH_FID_HI;
        if (last) fail_code = ST_MALFORMED;
      end
      PH_FID_HI: begin
        frame_num_reg_next = {b, frame_num_reg[DataW-1:0]};
        if (header_byte[BitDepFlag]) begin
          phase_next = PH_DEP;
          if (last) fail_code = ST_MALFORMED;
        end else begin
          phase_next      = PH_RES;
          byte_index_next = '0;
        end
      end
      PH_RES: begin
        resolution_reg_next = {resolution_reg[2*ResW-DataW-1:0], b};
        byte_index_next     = idx_inc;
        if (idx_inc >= ResIdxW'(ResBytes)) phase_next = PH_TAIL;
      end
      PH_DEP: begin
        pending_diff_next = b[DataW-1:DataW-PendW];
        more_pending_next = b[BitDepMore];
        if (b[BitDepExt]) begin
          phase_next = PH_DEP_EXT;
          if (last) fail_code = ST_MALFORMED;
        end else begin
          try_diff  = 1'b1;
          diff_cand = {{(DiffW-PendW){1'b0}}, b[DataW-1:DataW-PendW]};
          more_flag = b[BitDepMore];
        end
      end
      PH_DEP_EXT: begin
        try_diff  = 1'b1;
        diff_cand = {b, pending_diff};
        more_flag = more_pending;
      end
      default: begin
        // tail bytes and error phase: nothing to parse
      end
    endcase

    if (try_diff) begin
      if (diff_cand == '0 || dep_count >= DepCntW'(MAX_DEPENDENCIES)) begin
        fail_code = ST_REJECTED;
      end else begin
        diff_emit      = 1'b1;
        dep_count_next = dep_count + DepCntW'(1);
        if (more_flag) begin
          phase_next = PH_DEP;
          if (last) fail_code = ST_MALFORMED;  // chain cut short
        end else begin
          phase_next = PH_TAIL;
        end
      end
    end

    // first error wins
    if (fail_code != ST_OK) begin
      if (error_code_next == ST_OK) error_code_next = fail_code;
      phase_next = PH_ERR;
    end

    // descriptor seen after this byte's update
    desc_next.packet_edges   = header_byte_next[BitBegin:BitEnd];
    desc_next.frame_flags    = discard_mode ? {header_byte_next[BitFirst], 1'b0}
                                            : header_byte_next[BitFirst:BitLast];
    desc_next.temporal_layer = header_byte_next[BitBegin] ? header_byte_next[LayerW-1:0]
                                                          : '0;
    desc_next.spatial_mask   = spatial_reg_next;
    desc_next.frame_num      = frame_num_reg_next;
    if (byte_index_next == ResIdxW'(ResBytes)) begin
      desc_next.width  = resolution_reg_next[2*ResW-1:ResW];
      desc_next.height = resolution_reg_next[ResW-1:0];
    end else begin
      desc_next.width  = '0;
      desc_next.height = '0;
    end
    desc_next.status = error_code_next;

    if (last) phase_next = PH_FIRST;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_FIRST;
      header_byte    <= '0;
      byte_index     <= '0;
      spatial_reg    <= '0;
      frame_num_reg  <= '0;
      resolution_reg <= '0;
      pending_diff   <= '0;
      more_pending   <= 1'b0;
      dep_count      <= '0;
      error_code     <= ST_OK;
    end else if (in_xfer) begin
      phase          <= phase_next;
      header_byte    <= header_byte_next;
      byte_index     <= byte_index_next;
      spatial_reg    <= spatial_reg_next;
      frame_num_reg  <= frame_num_reg_next;
      resolution_reg <= resolution_reg_next;
      pending_diff   <= pending_diff_next;
      more_pending   <= more_pending_next;
      dep_count      <= dep_count_next;
      error_code     <= error_code_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result buffer; the difference goes out ahead of the descriptor.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
      desc_valid <= 1'b0;
    end else if (in_xfer) begin
      diff_valid <= diff_emit;
      desc_valid <= last;
    end else if (out_xfer) begin
      if (diff_valid) begin
        diff_valid <= 1'b0;
      end else begin
        desc_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      diff_data <= diff_cand;
      desc_data <= desc_next;
    end
  end

  assign result_out.valid          = diff_valid || desc_valid;
  assign result_out.kind           = diff_valid ? KindDiff : KindDesc;
  assign result_out.run_last       = diff_valid ? !desc_valid : 1'b1;
  assign result_out.packet_edges   = diff_valid ? '0 : desc_data.packet_edges;
  assign result_out.frame_flags    = diff_valid ? '0 : desc_data.frame_flags;
  assign result_out.temporal_layer = diff_valid ? '0 : desc_data.temporal_layer;
  assign result_out.spatial_mask   = diff_valid ? '0 : desc_data.spatial_mask;
  assign result_out.frame_num      = diff_valid ? '0 : desc_data.frame_num;
  assign result_out.width          = diff_valid ? '0 : desc_data.width;
  assign result_out.height         = diff_valid ? '0 : desc_data.height;
  assign result_out.dep_diff       = diff_valid ? diff_data : '0;
  assign result_out.status         = diff_valid ? ST_OK : desc_data.status;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_take_when_full: assert property (@(posedge clk) disable iff (rst)
    (diff_valid && desc_valid) |-> !byte_in.ready)
    else $error("byte taken while two results pending");

  a_last_gives_desc: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && last) |=> (desc_valid && phase == PH_FIRST))
    else $error("final byte did not queue a descriptor or rewind the parser");

  a_dep_count_cap: assert property (@(posedge clk) disable iff (rst)
    dep_count <= DepCntW'(MAX_DEPENDENCIES))
    else $error("dependency count past its limit");

  a_diff_needs_dep_phase: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && diff_emit) |-> (phase == PH_DEP || phase == PH_DEP_EXT))
    else $error("difference emitted outside the dependency chain");

endmodule
